### hw/rtl/llp_pkg.sv
`default_nettype none
package llp_pkg;

  localparam int MAX_CORES      = 8;
  localparam int CPU_ENTRIES    = 64;
  localparam int THREAD_ENTRIES = 64;
  localparam int NCELL  = (CPU_ENTRIES > THREAD_ENTRIES) ? CPU_ENTRIES : THREAD_ENTRIES;
  localparam int IDX_W  = $clog2(NCELL);
  localparam int CORE_W = 3;
  localparam int CNT_W  = 7;
  localparam logic [CNT_W-1:0] COUNT_TOP = '1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // opcodes
  localparam logic [1:0] OP_MARKER = 2'd0;
  localparam logic [1:0] OP_ACCESS = 2'd1;
  localparam logic [1:0] OP_EXIT   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_CORES  = 2'd0;
  localparam logic [1:0] REG_ENABLE = 2'd1;

  // search word that walks the cell chain
  typedef struct packed {
    logic              active;
    logic [31:0]       cpu_key;
    logic [31:0]       thr_key;
    logic              cpu_hit;
    logic [CORE_W-1:0] cpu_core;
    logic              cpu_free;
    logic [IDX_W-1:0]  cpu_free_idx;
    logic              thr_hit;
    logic [IDX_W-1:0]  thr_idx;
    logic [CORE_W-1:0] thr_core;
    logic              thr_free;
    logic [IDX_W-1:0]  thr_free_idx;
  } tok_t;

  // table update broadcast to all cells
  typedef struct packed {
    logic              cpu_we;
    logic [IDX_W-1:0]  cpu_idx;
    logic [31:0]       cpu_key;
    logic              thr_we;
    logic              thr_valid;
    logic [IDX_W-1:0]  thr_idx;
    logic [31:0]       thr_key;
    logic [CORE_W-1:0] core;
  } wr_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_HOLD = 3'b100
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/llp_cell.sv
`default_nettype none
module llp_cell import llp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic             cpu_en,
  input  wire logic             thr_en,
  input  wire tok_t             tok_i,
  input  wire wr_t              wr_i,
  output tok_t                  tok_o
);

  logic              cpu_v_r, thr_v_r;
  logic [31:0]       cpu_key_r, thr_key_r;
  logic [CORE_W-1:0] cpu_core_r, thr_core_r;
  tok_t              tok_r, tok_nxt;

  // merge this entry into the passing search word
  always_comb begin
    tok_nxt = tok_i;
    if (cpu_en) begin
      if (cpu_v_r && cpu_key_r == tok_i.cpu_key && !tok_i.cpu_hit) begin
        tok_nxt.cpu_hit  = 1'b1;
        tok_nxt.cpu_core = cpu_core_r;
      end
      if (!cpu_v_r && !tok_i.cpu_free) begin
        tok_nxt.cpu_free     = 1'b1;
        tok_nxt.cpu_free_idx = cell_idx;
      end
    end
    if (thr_en) begin
      if (thr_v_r && thr_key_r == tok_i.thr_key && !tok_i.thr_hit) begin
        tok_nxt.thr_hit  = 1'b1;
        tok_nxt.thr_idx  = cell_idx;
        tok_nxt.thr_core = thr_core_r;
      end
      if (!thr_v_r && !tok_i.thr_free) begin
        tok_nxt.thr_free     = 1'b1;
        tok_nxt.thr_free_idx = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_v_r <= 1'b0;
      thr_v_r <= 1'b0;
    end else begin
      if (cpu_en && wr_i.cpu_we && wr_i.cpu_idx == cell_idx) cpu_v_r <= 1'b1;
      if (thr_en && wr_i.thr_we && wr_i.thr_idx == cell_idx) thr_v_r <= wr_i.thr_valid;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (cpu_en && wr_i.cpu_we && wr_i.cpu_idx == cell_idx) begin
      cpu_key_r  <= wr_i.cpu_key;
      cpu_core_r <= wr_i.core;
    end
    if (thr_en && wr_i.thr_we && wr_i.thr_idx == cell_idx) begin
      thr_key_r  <= wr_i.thr_key;
      thr_core_r <= wr_i.core;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

### hw/rtl/least_loaded_thread_placer.sv
`default_nettype none
// Least-loaded thread placer.
// Input channel (in_valid/in_stall): one event word of opcode, thread id and
// cpu id. Output channel (out_valid/out_stall): one result word of core and
// status for every event. Config channel (cfg_valid/cfg_ready, ready always
// high): index 0 sets cores_in_use, index 1 sets cpu_sched_enable; write
// only while the block is idle.
// Both tables live in a chain of NCELL cells (64 here), one cpu entry and
// one thread entry per cell. An accepted event launches a search word that
// moves one cell per clock; the result is decided as the word leaves the
// chain and is then registered. One event is in flight at a time and input
// reopens the cycle after the result is registered.
// The result sits in an output register; the next event is accepted while
// that result still waits. If the receiver stalls long enough, the next
// result parks inside the block and input stalls until the register frees.
// Reset (synchronous, rst_n low) empties both tables, clears all per-core
// counts at once, and restores cores_in_use = 8, cpu_sched_enable = 0.
module least_loaded_thread_placer import llp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [31:0]        in_thread_id,
  input  wire logic signed [31:0] in_cpu_id,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_core,
  output logic [1:0]              out_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  state_t            state_r, state_nxt;
  logic [3:0]        cores_r;
  logic              en_r;
  logic [1:0]        op_r;
  logic [CNT_W-1:0]  cpc_r [MAX_CORES];
  logic [CNT_W-1:0]  tpc_r [MAX_CORES];
  logic [CNT_W-1:0]  cpc_nxt [MAX_CORES];
  logic [CNT_W-1:0]  tpc_nxt [MAX_CORES];
  logic              out_valid_r;
  logic [2:0]        out_core_r, res_core_r, res_core;
  logic [1:0]        out_status_r, res_status_r, res_status;
  tok_t              chain [NCELL+1];
  tok_t              tok_end;
  wr_t               wr;
  logic              in_acc, out_free, done;
  logic [3:0]        ncores;
  logic [CORE_W-1:0] min_cpu, min_thr;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign tok_end   = chain[NCELL];
  assign done      = tok_end.active;

  // search word injected at accept
  always_comb begin
    chain[0]         = '0;
    chain[0].active  = in_acc;
    chain[0].cpu_key = in_cpu_id;
    chain[0].thr_key = in_thread_id;
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    llp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .cpu_en   (g < CPU_ENTRIES),
      .thr_en   (g < THREAD_ENTRIES),
      .tok_i    (chain[g]),
      .wr_i     (wr),
      .tok_o    (chain[g+1])
    );
  end

  // clamp of cores_in_use and least-loaded searches, lowest core wins ties
  always_comb begin
    if (cores_r == 4'd0) ncores = 4'd1;
    else if (cores_r > 4'(MAX_CORES)) ncores = 4'(MAX_CORES);
    else ncores = cores_r;
    min_cpu = '0;
    min_thr = '0;
    for (int i = 1; i < MAX_CORES; i++) begin
      if (4'(i) < ncores && cpc_r[i] < cpc_r[min_cpu]) min_cpu = CORE_W'(i);
      if (4'(i) < ncores && tpc_r[i] < tpc_r[min_thr]) min_thr = CORE_W'(i);
    end
  end

  // decision when the search word leaves the chain
  always_comb begin
    logic [CORE_W-1:0] c;
    c          = '0;
    res_core   = '0;
    res_status = ST_OK;
    wr         = '0;
    cpc_nxt    = cpc_r;
    tpc_nxt    = tpc_r;
    wr.cpu_key = tok_end.cpu_key;
    wr.thr_key = tok_end.thr_key;
    if (done) begin
      unique case (op_r)
        OP_MARKER: begin
          if (!en_r || tok_end.cpu_key[31]) begin
            res_status = ST_IGNORED;
          end else if ((!tok_end.cpu_hit && !tok_end.cpu_free) ||
                       (!tok_end.thr_hit && !tok_end.thr_free)) begin
            res_status = ST_FULL;
          end else begin
            if (tok_end.cpu_hit) begin
              c = tok_end.cpu_core;
            end else begin
              c = min_cpu;
              if (cpc_nxt[c] < COUNT_TOP) cpc_nxt[c] = cpc_nxt[c] + 1'b1;
              wr.cpu_we  = 1'b1;
              wr.cpu_idx = tok_end.cpu_free_idx;
            end
            if (tok_end.thr_hit) begin
              if (tpc_nxt[tok_end.thr_core] != '0)
                tpc_nxt[tok_end.thr_core] = tpc_nxt[tok_end.thr_core] - 1'b1;
              wr.thr_idx = tok_end.thr_idx;
            end else begin
              wr.thr_idx = tok_end.thr_free_idx;
            end
            if (tpc_nxt[c] < COUNT_TOP) tpc_nxt[c] = tpc_nxt[c] + 1'b1;
            wr.thr_we    = 1'b1;
            wr.thr_valid = 1'b1;
            res_core     = c;
          end
        end
        OP_ACCESS: begin
          if (tok_end.thr_hit) begin
            res_core = tok_end.thr_core;
          end else if (!tok_end.thr_free) begin
            res_status = ST_FULL;
          end else begin
            c = min_thr;
            if (tpc_nxt[c] < COUNT_TOP) tpc_nxt[c] = tpc_nxt[c] + 1'b1;
            wr.thr_we    = 1'b1;
            wr.thr_valid = 1'b1;
            wr.thr_idx   = tok_end.thr_free_idx;
            res_core     = c;
          end
        end
        OP_EXIT: begin
          if (!tok_end.thr_hit) begin
            res_status = ST_UNKNOWN;
          end else begin
            c = tok_end.thr_core;
            if (tpc_nxt[c] != '0) tpc_nxt[c] = tpc_nxt[c] - 1'b1;
            wr.thr_we    = 1'b1;
            wr.thr_valid = 1'b0;
            wr.thr_idx   = tok_end.thr_idx;
            wr.core      = c;
            res_core     = c;
          end
        end
        default: res_status = ST_IGNORED;
      endcase
      if (op_r != OP_EXIT) wr.core = c;
    end
  end

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SRCH;
      S_SRCH: if (done) state_nxt = out_free ? S_IDLE : S_HOLD;
      S_HOLD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cores_r     <= 4'd8;
      en_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CORES; i++) begin
        cpc_r[i] <= '0;
        tpc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cpc_r   <= cpc_nxt;
      tpc_r   <= tpc_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CORES) cores_r <= cfg_data[3:0];
        else if (cfg_index == REG_ENABLE) en_r <= cfg_data[0];
      end
      if ((done || state_r == S_HOLD) && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) op_r <= in_opcode;
    if (done) begin
      res_core_r   <= res_core;
      res_status_r <= res_status;
    end
    if (done && out_free) begin
      out_core_r   <= res_core;
      out_status_r <= res_status;
    end else if (state_r == S_HOLD && out_free) begin
      out_core_r   <= res_core_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_core   = out_core_r;
  assign out_status = out_status_r;

  // checks
  a_acc_srch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_SRCH) else $error("accept did not start search");
  a_done_srch: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == S_SRCH) else $error("search word outside search");
  a_park: assert property (@(posedge clk) disable iff (!rst_n)
    done && out_valid_r && out_stall |=> state_r == S_HOLD && out_valid_r)
    else $error("blocked result not parked");

endmodule
`default_nettype wire
